// ----- design/barometer_pressure_compensation_assert.svh -----
// Assertion macros used by the top-level design file.
`ifndef BAROMETER_PRESSURE_COMPENSATION_ASSERT_SVH
`define BAROMETER_PRESSURE_COMPENSATION_ASSERT_SVH
// Implication checked at every rising edge outside reset.
`define BPC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Implication whose consequent is checked in the cycle after the antecedent.
`define BPC_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// ----- design/bpc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package bpc_pkg;
  localparam int unsigned DivBits = 32;
  // Pipeline slots: 1 front stage, 32 quotient cells, 3 middle stages, 32 cells, 3 back stages.
  localparam int unsigned Depth = 2 * DivBits + 7;

  typedef enum logic [2:0] {
    REG_OSS = 3'd0,
    REG_CAL_A = 3'd1,
    REG_CAL_B = 3'd2,
    REG_CAL_C = 3'd3,
    REG_CAL_D = 3'd4,
    REG_CAL_E = 3'd5
  } reg_idx_t;

  // Data carried alongside a division through the cells.
  typedef struct packed {
    logic [31:0] b5;
    logic [31:0] b7;
    logic [1:0]  oss;
    logic        big;
    logic        err;
    logic [31:0] b4;
  } bpc_side_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] rem;
    logic [31:0] quo;
    logic [31:0] dvd;
    logic [31:0] dvs;
    logic        neg;
    bpc_side_t   side;
  } bpc_cell_t;

  function automatic logic [31:0] asr(input logic [31:0] v, input int unsigned n);
    asr = 32'($signed(v) >>> n);
  endfunction

  function automatic logic [31:0] sx16(input logic [15:0] h);
    sx16 = {{16{h[15]}}, h};
  endfunction
endpackage
`default_nettype wire

// ----- design/barometer_pressure_compensation.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Integer pressure compensation for a barometric sensor. Each transfer on the input
// channel carries one raw temperature and one raw pressure reading and yields exactly
// one result transfer with the temperature term B5, the temperature in tenths of a
// degree, the pressure in pascals and a flag raised when either divisor was zero (all
// values are then zero). The block takes one item per cycle while not stalled; it is
// built from two rows of 32 division cells (one quotient bit each) for the temperature and
// pressure divisions, plus seven registered arithmetic stages. The whole pipeline
// advances when the output register is empty or being read, so a stalled consumer
// stalls the input. Configuration must only be written while the pipeline is empty.
module barometer_pressure_compensation
  import bpc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [15:0] raw_temp,
  input  wire logic [18:0] raw_pressure,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      temp_comp_term,
  output logic [27:0]      temperature_tenths,
  output logic [31:0]      comp_pressure,
  output logic             div_error
);
  logic [1:0]  oss;
  logic [31:0] cal_a, cal_b, cal_c, cal_d, cal_e;
  logic        en;

  always_ff @(posedge clk) begin
    if (rst) begin
      oss <= 2'd1;
      cal_a <= '0; cal_b <= '0; cal_c <= '0; cal_d <= '0; cal_e <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_OSS:   oss <= cfg_data[1:0];
        REG_CAL_A: cal_a <= cfg_data;
        REG_CAL_B: cal_b <= cfg_data;
        REG_CAL_C: cal_c <= cfg_data;
        REG_CAL_D: cal_d <= cfg_data;
        REG_CAL_E: cal_e <= cfg_data;
        default: ;
      endcase
    end
  end

  // The pipeline moves whenever the output register can take a new value.
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // Front stage: X1 = ((UT-AC6)*AC5)>>15 and the temperature divisor.
  logic        f_valid;
  logic [31:0] f_x1, f_mc, f_md;
  logic [18:0] f_up;
  logic [31:0] mul_t;
  assign mul_t = ({16'd0, raw_temp} - {16'd0, cal_c[15:0]}) * {16'd0, cal_c[31:16]};

  always_ff @(posedge clk) begin
    if (rst) f_valid <= 1'b0;
    else if (en) f_valid <= in_valid;
    if (en) begin
      f_x1 <= asr(mul_t, 15);
      f_mc <= sx16(cal_e[31:16]);
      f_md <= sx16(cal_e[15:0]);
      f_up <= raw_pressure;
    end
  end

  // Temperature division: (MC<<11) / (X1+MD), signed, truncating.
  bpc_cell_t t_in, t_out;
  logic [31:0] den, num;
  always_comb begin
    den = f_x1 + f_md;
    num = f_mc << 11;
    t_in = '0;
    t_in.valid = f_valid;
    t_in.dvd = num[31] ? 32'(0 - num) : num;
    t_in.dvs = den[31] ? 32'(0 - den) : den;
    t_in.neg = num[31] ^ den[31];
    t_in.side.b5  = f_x1;
    t_in.side.b7  = {13'd0, f_up};
    t_in.side.err = (den == '0);
  end

  bpc_div_chain u_tdiv (.clk(clk), .rst(rst), .en(en), .din(t_in), .dout(t_out));

  // Middle stage A: B5, B6, sq and the first products.
  logic        m_valid, m_err;
  logic [31:0] m_b5, m_b6, m_sq, m_up;
  logic [31:0] x2t, b5c, b6c, sqp;
  assign x2t = t_out.neg ? 32'(0 - t_out.quo) : t_out.quo;
  assign b5c = t_out.side.b5 + x2t;
  assign b6c = b5c - 32'd4000;
  assign sqp = b6c * b6c;

  always_ff @(posedge clk) begin
    if (rst) m_valid <= 1'b0;
    else if (en) m_valid <= t_out.valid;
    if (en) begin
      m_err <= t_out.side.err;
      m_b5  <= b5c;
      m_b6  <= b6c;
      m_sq  <= asr(sqp, 12);
      m_up  <= t_out.side.b7;
    end
  end

  // Middle stage B: B3 and the X3 term that scales AC4 into B4.
  logic        n_valid, n_err;
  logic [31:0] n_b5, n_b3, n_x3, n_up;
  logic [31:0] p1, p2, p3, p4, x3a, b3c, x3b;
  always_comb begin
    p1  = asr(sx16(cal_d[15:0]) * m_sq, 11);
    p2  = asr(sx16(cal_a[15:0]) * m_b6, 11);
    x3a = p1 + p2;
    b3c = asr(((sx16(cal_a[31:16]) * 32'd4 + x3a) << oss) + 32'd2, 2);
    p3  = asr(sx16(cal_b[31:16]) * m_b6, 13);
    p4  = asr(sx16(cal_d[31:16]) * m_sq, 16);
    x3b = asr(p3 + p4 + 32'd2, 2);
  end

  always_ff @(posedge clk) begin
    if (rst) n_valid <= 1'b0;
    else if (en) n_valid <= m_valid;
    if (en) begin
      n_err <= m_err;
      n_b5  <= m_b5;
      n_b3  <= b3c;
      n_x3  <= x3b;
      n_up  <= m_up;
    end
  end

  // Middle stage C: B4, so that its product does not follow the X3 products.
  logic        o_valid, o_err;
  logic [31:0] o_b5, o_b3, o_b4, o_up;
  logic [31:0] b4p;
  assign b4p = {16'd0, cal_b[15:0]} * (n_x3 + 32'd32768);

  always_ff @(posedge clk) begin
    if (rst) o_valid <= 1'b0;
    else if (en) o_valid <= n_valid;
    if (en) begin
      o_err <= n_err;
      o_b5  <= n_b5;
      o_b3  <= n_b3;
      o_b4  <= b4p >> 15;
      o_up  <= n_up;
    end
  end

  logic [31:0] b7;
  bpc_cell_t   p_in, p_out;
  assign b7 = (o_up - o_b3) * (32'd50000 >> oss);
  always_comb begin
    p_in = '0;
    p_in.valid    = o_valid;
    p_in.dvd      = b7[31] ? b7 : {b7[30:0], 1'b0};
    p_in.dvs      = o_b4;
    p_in.side.b5  = o_b5;
    p_in.side.big = b7[31];
    p_in.side.err = o_err || (o_b4 == '0);
  end

  bpc_div_chain u_pdiv (.clk(clk), .rst(rst), .en(en), .din(p_in), .dout(p_out));

  // Back stage 1: p and its square term.
  logic        q_valid, q_err;
  logic [31:0] q_b5, q_p, q_sq;
  logic [31:0] pq, ps;
  assign pq = p_out.side.big ? {p_out.quo[30:0], 1'b0} : p_out.quo;
  assign ps = asr(pq, 8);

  always_ff @(posedge clk) begin
    if (rst) q_valid <= 1'b0;
    else if (en) q_valid <= p_out.valid;
    if (en) begin
      q_err <= p_out.side.err;
      q_b5  <= p_out.side.b5;
      q_p   <= pq;
      q_sq  <= ps * ps;
    end
  end

  // Back stage 2: the two correction products.
  logic        r_valid, r_err;
  logic [31:0] r_b5, r_p, r_x1, r_x2;
  logic [31:0] c1p, c2p;
  assign c1p = q_sq * 32'd3038;
  assign c2p = (32'd0 - 32'd7357) * q_p;

  always_ff @(posedge clk) begin
    if (rst) r_valid <= 1'b0;
    else if (en) r_valid <= q_valid;
    if (en) begin
      r_err <= q_err;
      r_b5  <= q_b5;
      r_p   <= q_p;
      r_x1  <= asr(c1p, 16);
      r_x2  <= asr(c2p, 16);
    end
  end

  // Output register.
  logic [31:0] pfin, tt;
  assign pfin = r_p + asr(r_x1 + r_x2 + 32'd3791, 4);
  assign tt   = asr(r_b5 + 32'd8, 4);

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= r_valid;
    if (en) begin
      div_error          <= r_err;
      temp_comp_term     <= r_err ? '0 : r_b5;
      temperature_tenths <= r_err ? '0 : tt[27:0];
      comp_pressure      <= r_err ? '0 : pfin;
    end
  end

`include "barometer_pressure_compensation_assert.svh"
  `BPC_ASSERT_IMP(a_err_zero, out_valid && div_error, comp_pressure == '0 && temp_comp_term == '0, "error result not zero")
  `BPC_ASSERT_NXT(a_stall_hold, out_valid && !out_ready, out_valid && $stable(comp_pressure), "stalled result changed")
  `BPC_ASSERT_IMP(a_ready, out_valid && !out_ready, !in_ready, "input taken while output blocked")
endmodule
`default_nettype wire

// ----- design/bpc_div_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
// One restoring-division cell: produces one quotient bit, MSB first, and hands on.
module bpc_div_cell
  import bpc_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      en,
  input  wire bpc_cell_t din,
  output bpc_cell_t      dout
);
  logic [32:0] trial;
  logic [32:0] diff;
  bpc_cell_t   nxt;

  always_comb begin
    nxt   = din;
    trial = {din.rem, din.dvd[31]};
    diff  = trial - {1'b0, din.dvs};
    nxt.dvd = {din.dvd[30:0], 1'b0};
    if (!diff[32]) begin
      nxt.rem = diff[31:0];
      nxt.quo = {din.quo[30:0], 1'b1};
    end else begin
      nxt.rem = trial[31:0];
      nxt.quo = {din.quo[30:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (en) begin
      dout.valid <= din.valid;
    end
    if (en) begin
      dout.rem  <= nxt.rem;
      dout.quo  <= nxt.quo;
      dout.dvd  <= nxt.dvd;
      dout.dvs  <= nxt.dvs;
      dout.neg  <= nxt.neg;
      dout.side <= nxt.side;
    end
  end
endmodule
`default_nettype wire

// ----- design/bpc_div_chain.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Row of division cells; one quotient bit per cell, one new division each cycle while en is high.
module bpc_div_chain
  import bpc_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      en,
  input  wire bpc_cell_t din,
  output bpc_cell_t      dout
);
  bpc_cell_t link [DivBits+1];

  assign link[0] = din;
  for (genvar i = 0; i < DivBits; i++) begin : g_cell
    bpc_div_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .en   (en),
      .din  (link[i]),
      .dout (link[i+1])
    );
  end
  assign dout = link[DivBits];
endmodule
`default_nettype wire
